// ----- design/tdr_pkg.sv -----
// Package for the triangle depth rasteriser: request and result types, codes, constants.
// Depends on nothing; used by triangle_depth_rasterizer.
`default_nettype none
package tdr_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic signed [23:0] DEPTH_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] DEPTH_ONE = 24'sh400000;
  localparam logic [14:0]        COUNT_MAX = 15'h7FFF;
  localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [23:0] z0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [23:0] z1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic signed [23:0] z2;
    logic [23:0]        fill_rgb;
    logic [13:0]        read_index;
  } req_t;

  typedef struct packed {
    logic [31:0]        pixel_color;
    logic signed [23:0] pixel_depth;
    logic [14:0]        pixels_written;
  } res_t;

endpackage
`default_nettype wire

// ----- design/tdr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module tdr_ram #(
  parameter int Width = 32,
  parameter int Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/tdr_divider.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; used by triangle_depth_rasterizer.
`default_nettype none
module tdr_divider #(
  parameter int NumW = 64,
  parameter int DenW = 36
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [NumW-1:0] num_i,
  input  wire logic        [DenW-1:0] den_i,
  output logic                        done_o,
  output logic signed [NumW-1:0]      quo_o
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_q, q_d;
  logic [DenW:0]   r_q, r_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic [DenW:0]   trial;

  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; neg_d = neg_q; cnt_d = cnt_q; run_d = run_q;
    trial = {r_q[DenW-1:0], q_q[NumW-1]};
    done_o = 1'b0;
    if (start_i) begin
      neg_d = num_i[NumW-1];
      q_d   = num_i[NumW-1] ? (~num_i + 1'b1) : num_i;
      r_d   = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      // shift in one numerator bit, subtract where it fits
      if (trial >= {1'b0, den_q}) begin
        r_d = trial - {1'b0, den_q};
        q_d = {q_q[NumW-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_comb begin
    quo_o = neg_q ? -$signed(q_d) : $signed(q_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d; neg_q <= neg_d;
  end
endmodule
`default_nettype wire

// ----- design/triangle_depth_rasterizer.sv -----
// Top level of the triangle depth rasteriser: sequencer, edge test, depth test, stores.
// Depends on tdr_pkg, tdr_ram and tdr_divider.
`default_nettype none
// One request at a time; busy is high from acceptance until the result strobe.
// After reset a clearing pass writes every pixel, setting the stores to black
// and maximum depth; busy stays high meanwhile. A clear request writes every
// pixel with the clear colour and answers. A read returns the registered data.
// A draw computes the area, then per pixel tests whether the centre is in the
// triangle and, where covered, runs the 64-step bit-serial depth divider before
// the depth test. A draw with an area of zero or less visits no pixel.
// Results appear for one cycle on result_o with result_valid_o; they cannot stall.
module triangle_depth_rasterizer #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 128
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire tdr_pkg::req_t  req_i,
  input  wire logic           cfg_we_i,
  input  wire logic [31:0]    cfg_wdata_i,
  output logic                result_valid_o,
  output tdr_pkg::res_t       result_o
);
  localparam int PixCount = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AddrW = (PixCount > 1) ? $clog2(PixCount) : 1;
  localparam int XW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FILL  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_AREA  = 9'b000001000,
    ST_EDGE  = 9'b000010000,
    ST_TEST  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_WRITE = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  tdr_pkg::req_t req_q, req_d;
  logic [31:0] clear_color_q;
  logic [AddrW:0] pix_q, pix_d;
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [14:0] count_q, count_d;
  logic signed [35:0] area_q, area_d;
  logic signed [35:0] w0_q, w1_q, w2_q, w0_d, w1_d, w2_d;
  logic signed [63:0] num_q, num_d;
  logic fill_init_q, fill_init_d;
  logic signed [23:0] depth_q, depth_d;
  logic result_valid_d;
  tdr_pkg::res_t result_d;

  // store ports
  logic             st_we;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [31:0]      col_wdata, col_rdata;
  logic [23:0]      dep_wdata, dep_rdata;

  tdr_ram #(.Width(32), .Depth(PixCount)) u_color (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(col_wdata),
    .raddr_i(st_raddr), .rdata_o(col_rdata)
  );
  tdr_ram #(.Width(24), .Depth(PixCount)) u_depth (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(dep_wdata),
    .raddr_i(st_raddr), .rdata_o(dep_rdata)
  );

  logic div_start, div_done;
  logic signed [63:0] div_quo;
  tdr_divider #(.NumW(64), .DenW(36)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q),
    .den_i(area_q[35:0]), .done_o(div_done), .quo_o(div_quo)
  );

  // edge function (c-a)x(b-a); 19-bit differences, 36-bit products
  function automatic logic signed [35:0] edge_fn(
    input logic signed [17:0] ax, input logic signed [17:0] ay,
    input logic signed [17:0] bx, input logic signed [17:0] by,
    input logic signed [17:0] cx, input logic signed [17:0] cy);
    logic signed [18:0] dx1, dy1, dx2, dy2;
    logic signed [35:0] p1, p2;
    dx1 = 19'(cx) - 19'(ax); dy1 = 19'(by) - 19'(ay);
    dx2 = 19'(bx) - 19'(ax); dy2 = 19'(cy) - 19'(ay);
    p1 = 36'(dx1) * 36'(dy1);
    p2 = 36'(dy2) * 36'(dx2);
    return p1 - p2;
  endfunction

  logic signed [17:0] px, py;
  logic signed [17:0] vx0, vy0, vx1, vy1, vx2, vy2;
  logic [AddrW-1:0] pix_addr;
  logic [YW-1:0] flip_row;
  logic signed [59:0] pz0, pz1, pz2;

  always_comb begin
    vx0 = 18'(req_q.x0); vy0 = 18'(req_q.y0);
    vx1 = 18'(req_q.x1); vy1 = 18'(req_q.y1);
    vx2 = 18'(req_q.x2); vy2 = 18'(req_q.y2);
    px = $signed({1'b0, 17'({col_q, 4'h8})});
    py = $signed({1'b0, 17'({row_q, 4'h8})});
    flip_row = YW'(FRAME_HEIGHT - 1) - row_q;
    pix_addr = AddrW'(AddrW'(flip_row) * AddrW'(FRAME_WIDTH) + AddrW'(col_q));
    pz0 = 60'(req_q.z0) * 60'(w0_q);
    pz1 = 60'(req_q.z1) * 60'(w1_q);
    pz2 = 60'(req_q.z2) * 60'(w2_q);
  end

  always_comb begin
    state_d = state_q; req_d = req_q; pix_d = pix_q; col_d = col_q; row_d = row_q;
    count_d = count_q; area_d = area_q; w0_d = w0_q; w1_d = w1_q; w2_d = w2_q;
    num_d = num_q; fill_init_d = fill_init_q; depth_d = depth_q;
    result_valid_d = 1'b0; result_d = '0;
    st_we = 1'b0; st_waddr = pix_addr; st_raddr = pix_addr;
    col_wdata = {tdr_pkg::ALPHA_OPAQUE, req_q.fill_rgb}; dep_wdata = depth_q;
    div_start = 1'b0;
    busy = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          col_d = '0; row_d = '0; pix_d = '0; count_d = '0;
          case (req_i.req_type)
            tdr_pkg::REQ_CLEAR: state_d = ST_FILL;
            tdr_pkg::REQ_DRAW:  state_d = ST_AREA;
            tdr_pkg::REQ_READ:  state_d = ST_READ;
            default:            state_d = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        st_we = 1'b1;
        st_waddr = pix_q[AddrW-1:0];
        col_wdata = fill_init_q ? 32'd0 : clear_color_q;
        dep_wdata = tdr_pkg::DEPTH_MAX;
        pix_d = pix_q + 1'b1;
        if (pix_q == (AddrW+1)'(PixCount - 1)) begin
          if (fill_init_q) begin
            fill_init_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        // address this cycle, data next
        st_raddr = AddrW'(req_q.read_index);
        if (pix_q[0]) begin
          if (32'(req_q.read_index) < 32'(PixCount)) begin
            result_d.pixel_color = col_rdata;
            result_d.pixel_depth = dep_rdata;
          end
          result_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
        pix_d = pix_q + 1'b1;
      end
      ST_AREA: begin
        area_d = edge_fn(vx0, vy0, vx1, vy1, vx2, vy2);
        state_d = ST_EDGE;
      end
      ST_EDGE: begin
        if (area_q <= 0) begin
          state_d = ST_DONE;
        end else begin
          w0_d = edge_fn(vx1, vy1, vx2, vy2, px, py);
          w1_d = edge_fn(vx2, vy2, vx0, vy0, px, py);
          w2_d = edge_fn(vx0, vy0, vx1, vy1, px, py);
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        num_d = 64'(pz0) + 64'(pz1) + 64'(pz2);
        if (w0_q < 0 || w1_q < 0 || w2_q < 0) begin
          state_d = ST_WRITE;
          fill_init_d = 1'b0;
          depth_d = tdr_pkg::DEPTH_MAX;
        end else begin
          div_start = 1'b0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // launch once on entry (pix_q bit AddrW flags launched)
        if (!pix_q[AddrW]) begin
          div_start = 1'b1;
          pix_d[AddrW] = 1'b1;
        end else if (div_done) begin
          pix_d[AddrW] = 1'b0;
          if (div_quo <= 64'(tdr_pkg::DEPTH_ONE) &&
              div_quo < 64'($signed(dep_rdata))) begin
            depth_d = div_quo[23:0];
            st_we = 1'b1;
            col_wdata = {tdr_pkg::ALPHA_OPAQUE, req_q.fill_rgb};
            dep_wdata = div_quo[23:0];
            if (count_q != tdr_pkg::COUNT_MAX) count_d = count_q + 1'b1;
          end
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // advance to the next pixel
        if (col_q == XW'(FRAME_WIDTH - 1)) begin
          col_d = '0;
          if (row_q == YW'(FRAME_HEIGHT - 1)) begin
            state_d = ST_DONE;
          end else begin
            row_d = row_q + 1'b1;
            state_d = ST_EDGE;
          end
        end else begin
          col_d = col_q + 1'b1;
          state_d = ST_EDGE;
        end
      end
      ST_DONE: begin
        result_valid_d = 1'b1;
        if (req_q.req_type == tdr_pkg::REQ_DRAW) result_d.pixels_written = count_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_FILL;
      fill_init_q    <= 1'b1;
      pix_q          <= '0;
      clear_color_q  <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      fill_init_q    <= fill_init_d;
      pix_q          <= pix_d;
      result_valid_o <= result_valid_d;
      if (cfg_we_i) clear_color_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; col_q <= col_d; row_q <= row_d; count_q <= count_d;
    area_q <= area_d; w0_q <= w0_d; w1_q <= w1_d; w2_q <= w2_d;
    num_q <= num_d; depth_q <= depth_d; result_o <= result_d;
  end

  // a result never appears while idle with no request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without request");
  // stores are never written while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !st_we) else $error("store write while idle");
  // a request started while idle is taken and raises busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not held");
endmodule
`default_nettype wire
